FILE: rtl/rcpd_pkg.sv
package rcpd_pkg;

	// Timestamp widths
	localparam int TIME_WIDTH_DEF = 32;
	localparam int TS_W           = 32;

	// Channel layout
	localparam int NUM_CH    = 4;
	localparam int CH_SPEED  = 0;
	localparam int CH_STEER  = 1;
	localparam int CH_MOW    = 2;
	localparam int CH_SWITCH = 3;

	// Field widths
	localparam int PCT_W   = 9;
	localparam int MOW_W   = 7;
	localparam int DRIVE_W = 10;
	localparam int DIFF_W  = 9;

	// Config port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CENTER     = 3'd0,
		REG_DEAD_BAND  = 3'd1,
		REG_ARM_WINDOW = 3'd2,
		REG_SPEED_MIN  = 3'd3,
		REG_MOW_MAX    = 3'd4
	} cfg_reg_t;

	// Percent conversion: pct = diff * 5 / 17, done as (diff * RECIP_MUL) >> RECIP_SHIFT.
	// Exact for diff below DIFF_SAT.
	localparam logic [8:0]  PCT_LIMIT   = 9'd150;
	localparam logic [9:0]  DIFF_SAT    = 10'd510;
	localparam logic [14:0] RECIP_MUL   = 15'd19280;
	localparam int          RECIP_SHIFT = 16;
	localparam int          PROD_W      = 24;
	localparam logic signed [DRIVE_W-1:0] MOW_OFFSET = 10'sd100;

	// Register reset values
	localparam logic [15:0] CENTER_RST     = 16'd1500;
	localparam logic [4:0]  DEAD_BAND_RST  = 5'd5;
	localparam logic [31:0] ARM_WINDOW_RST = 32'd10000000;
	localparam logic [7:0]  SPEED_MIN_RST  = 8'd20;
	localparam logic [7:0]  MOW_MAX_RST    = 8'd20;

	typedef struct packed {
		logic [15:0] center;
		logic [4:0]  dead_band;
		logic [31:0] arm_window;
		logic [7:0]  speed_min;
		logic [7:0]  mow_max;
	} cfg_t;

	// Stage enables from the top level to each lane
	typedef struct packed {
		logic load_s1;
		logic load_s2;
	} lane_ctl_t;

	// What a lane found for the item in its last stage
	typedef struct packed {
		logic                    fall;
		logic signed [PCT_W-1:0] pct;
	} lane_res_t;

endpackage

FILE: rtl/rcpd_lane.sv
module rcpd_lane #(
	parameter int TIME_WIDTH = rcpd_pkg::TIME_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  rcpd_pkg::lane_ctl_t   ctl,
	input  logic [TIME_WIDTH-1:0] t,
	input  logic                  level,
	input  logic [15:0]           center,
	input  logic [4:0]            dead_band,
	output rcpd_pkg::lane_res_t   res
);

	logic                  last_level_q;
	logic [TIME_WIDTH-1:0] rise_time_q;

	logic                          fall_s1;
	logic                          neg_s1;
	logic                          sat_s1;
	logic [rcpd_pkg::DIFF_W-1:0]   diff_s1;
	rcpd_pkg::lane_res_t           res_s2;

	logic                  rise;
	logic                  fall;
	logic [TIME_WIDTH-1:0] width;
	logic [TIME_WIDTH-1:0] center_ext;
	logic                  ge;
	logic [TIME_WIDTH-1:0] diff;
	logic                  sat;

	logic [rcpd_pkg::PROD_W-1:0] prod;
	logic [rcpd_pkg::PCT_W-1:0]  mag;
	logic [rcpd_pkg::PCT_W-1:0]  mag_db;
	logic [rcpd_pkg::PCT_W-1:0]  pct;

	// Edge detect and wrapping pulse width against center
	always_comb begin
		rise       = level & ~last_level_q;
		fall       = ~level & last_level_q;
		width      = t - rise_time_q;
		center_ext = TIME_WIDTH'(center);
		ge         = width >= center_ext;
		diff       = ge ? (width - center_ext) : (center_ext - width);
		sat        = diff >= TIME_WIDTH'(rcpd_pkg::DIFF_SAT);
	end

	// Pin state, updated on every input transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_level_q <= 1'b0;
			rise_time_q  <= '0;
		end else if (ctl.load_s1) begin
			last_level_q <= level;
			if (rise) begin
				rise_time_q <= t;
			end
		end
	end

	// Stage 1
	always_ff @(posedge clk) begin
		if (ctl.load_s1) begin
			fall_s1 <= fall;
			neg_s1  <= ~ge;
			sat_s1  <= sat;
			diff_s1 <= diff[rcpd_pkg::DIFF_W-1:0];
		end
	end

	// Scale by 5/17, saturate, deadband, sign
	always_comb begin
		prod = rcpd_pkg::PROD_W'(diff_s1) * rcpd_pkg::PROD_W'(rcpd_pkg::RECIP_MUL);
		mag  = sat_s1 ? rcpd_pkg::PCT_LIMIT
			: rcpd_pkg::PCT_W'(prod[rcpd_pkg::PROD_W-1:rcpd_pkg::RECIP_SHIFT]);
		mag_db = (mag < rcpd_pkg::PCT_W'(dead_band)) ? '0 : mag;
		pct    = neg_s1 ? (~mag_db + 9'd1) : mag_db;
	end

	// Stage 2
	always_ff @(posedge clk) begin
		if (ctl.load_s2) begin
			res_s2.fall <= fall_s1;
			res_s2.pct  <= pct;
		end
	end

	assign res = res_s2;

endmodule

FILE: rtl/rcpd_merge.sv
module rcpd_merge (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    load,
	input  rcpd_pkg::lane_res_t [rcpd_pkg::NUM_CH-1:0] lane_res,
	input  logic                                    win,
	input  rcpd_pkg::cfg_t                          cfg,
	output logic signed [rcpd_pkg::PCT_W-1:0]       speed_pct,
	output logic signed [rcpd_pkg::PCT_W-1:0]       steer_pct,
	output logic [rcpd_pkg::MOW_W-1:0]              mow_pct,
	output logic signed [rcpd_pkg::PCT_W-1:0]       switch_pct,
	output logic signed [rcpd_pkg::DRIVE_W-1:0]     left_drive,
	output logic signed [rcpd_pkg::DRIVE_W-1:0]     right_drive,
	output logic [rcpd_pkg::MOW_W-1:0]              mow_drive,
	output logic                                    armed
);

	logic signed [rcpd_pkg::PCT_W-1:0] cv_q [rcpd_pkg::NUM_CH];
	logic                              armed_q;

	logic signed [rcpd_pkg::PCT_W-1:0]   cv_n [rcpd_pkg::NUM_CH];
	logic signed [rcpd_pkg::DRIVE_W-1:0] mow_sum;
	logic signed [rcpd_pkg::PCT_W-1:0]   mow_val;
	logic [rcpd_pkg::PCT_W-1:0]          speed_mag;
	logic                                arm_hit;
	logic                                armed_n;
	logic signed [rcpd_pkg::DRIVE_W-1:0] speed_x;
	logic signed [rcpd_pkg::DRIVE_W-1:0] steer_x;
	logic signed [rcpd_pkg::DRIVE_W-1:0] steer_sgn;
	logic signed [rcpd_pkg::DRIVE_W-1:0] left_n;
	logic signed [rcpd_pkg::DRIVE_W-1:0] right_n;

	// Mow channel rescale: max(0, (p + 100) / 2)
	always_comb begin
		mow_sum = rcpd_pkg::DRIVE_W'(lane_res[rcpd_pkg::CH_MOW].pct) + rcpd_pkg::MOW_OFFSET;
		mow_val = (mow_sum > 10'sd0) ? rcpd_pkg::PCT_W'(mow_sum >>> 1) : '0;
	end

	// Channel values after this item's falling edges
	always_comb begin
		for (int i = 0; i < rcpd_pkg::NUM_CH; i++) begin
			cv_n[i] = cv_q[i];
			if (lane_res[i].fall) begin
				cv_n[i] = (i == rcpd_pkg::CH_MOW) ? mow_val : lane_res[i].pct;
			end
		end
	end

	// Sticky arm test and differential mix
	always_comb begin
		speed_mag = cv_n[rcpd_pkg::CH_SPEED][rcpd_pkg::PCT_W-1]
			? rcpd_pkg::PCT_W'(-cv_n[rcpd_pkg::CH_SPEED])
			: rcpd_pkg::PCT_W'(cv_n[rcpd_pkg::CH_SPEED]);
		arm_hit = win
			&& (speed_mag > rcpd_pkg::PCT_W'(cfg.speed_min))
			&& (rcpd_pkg::PCT_W'(cv_n[rcpd_pkg::CH_MOW]) < rcpd_pkg::PCT_W'(cfg.mow_max));
		armed_n   = armed_q | arm_hit;
		speed_x   = rcpd_pkg::DRIVE_W'(cv_n[rcpd_pkg::CH_SPEED]);
		steer_x   = rcpd_pkg::DRIVE_W'(cv_n[rcpd_pkg::CH_STEER]);
		steer_sgn = speed_x[rcpd_pkg::DRIVE_W-1] ? -steer_x : steer_x;
		left_n    = speed_x - steer_sgn;
		right_n   = speed_x + steer_sgn;
	end

	// Channel state and arm flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < rcpd_pkg::NUM_CH; i++) begin
				cv_q[i] <= '0;
			end
			armed_q <= 1'b0;
		end else if (load) begin
			for (int i = 0; i < rcpd_pkg::NUM_CH; i++) begin
				cv_q[i] <= cv_n[i];
			end
			armed_q <= armed_n;
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (load) begin
			speed_pct   <= cv_n[rcpd_pkg::CH_SPEED];
			steer_pct   <= cv_n[rcpd_pkg::CH_STEER];
			mow_pct     <= cv_n[rcpd_pkg::CH_MOW][rcpd_pkg::MOW_W-1:0];
			switch_pct  <= cv_n[rcpd_pkg::CH_SWITCH];
			left_drive  <= armed_n ? left_n : '0;
			right_drive <= armed_n ? right_n : '0;
			mow_drive   <= armed_n ? cv_n[rcpd_pkg::CH_MOW][rcpd_pkg::MOW_W-1:0] : '0;
			armed       <= armed_n;
		end
	end

endmodule

FILE: rtl/rc_pulse_decoder_mixer_core.sv
// Three register stages: two lane stages and the merge output register. The first is
// loaded at the input transfer edge; out_valid rises as the merge output register loads.
// Throughput: one item per cycle, set by four parallel lanes, unless out_ready stalls.
// The pipeline stages advance independently, so bubbles are filled while a result waits.
// Reset (arst_n low, asynchronous): pipeline empty, pin levels low, rise times and
// channel values zero, disarmed, registers back to their default values.
module rc_pulse_decoder_mixer_core #(
	parameter int TIME_WIDTH = rcpd_pkg::TIME_WIDTH_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [rcpd_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [rcpd_pkg::CFG_DATA_W-1:0]       cfg_data,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic [rcpd_pkg::TS_W-1:0]             time_us,
	input  logic                                  speed_level,
	input  logic                                  steer_level,
	input  logic                                  mow_level,
	input  logic                                  switch_level,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [rcpd_pkg::PCT_W-1:0]     speed_pct,
	output logic signed [rcpd_pkg::PCT_W-1:0]     steer_pct,
	output logic [rcpd_pkg::MOW_W-1:0]            mow_pct,
	output logic signed [rcpd_pkg::PCT_W-1:0]     switch_pct,
	output logic signed [rcpd_pkg::DRIVE_W-1:0]   left_drive,
	output logic signed [rcpd_pkg::DRIVE_W-1:0]   right_drive,
	output logic [rcpd_pkg::MOW_W-1:0]            mow_drive,
	output logic                                  armed
);

	localparam int CMP_W = (TIME_WIDTH > rcpd_pkg::TS_W) ? TIME_WIDTH : rcpd_pkg::TS_W;

	rcpd_pkg::cfg_t cfg_q;

	logic v_s1;
	logic v_s2;
	logic out_valid_q;
	logic win_s1;
	logic win_s2;

	logic adv1;
	logic adv2;
	logic adv3;
	logic in_xfer;
	logic merge_load;

	logic [CMP_W-1:0]      time_ext;
	logic [TIME_WIDTH-1:0] t;
	logic                  win;

	rcpd_pkg::lane_ctl_t                         ctl;
	rcpd_pkg::lane_res_t [rcpd_pkg::NUM_CH-1:0] lane_res;
	logic [rcpd_pkg::NUM_CH-1:0]                levels;

	// Config register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.center     <= rcpd_pkg::CENTER_RST;
			cfg_q.dead_band  <= rcpd_pkg::DEAD_BAND_RST;
			cfg_q.arm_window <= rcpd_pkg::ARM_WINDOW_RST;
			cfg_q.speed_min  <= rcpd_pkg::SPEED_MIN_RST;
			cfg_q.mow_max    <= rcpd_pkg::MOW_MAX_RST;
		end else if (cfg_we) begin
			case (rcpd_pkg::cfg_reg_t'(cfg_index))
				rcpd_pkg::REG_CENTER:     cfg_q.center     <= cfg_data[15:0];
				rcpd_pkg::REG_DEAD_BAND:  cfg_q.dead_band  <= cfg_data[4:0];
				rcpd_pkg::REG_ARM_WINDOW: cfg_q.arm_window <= cfg_data[31:0];
				rcpd_pkg::REG_SPEED_MIN:  cfg_q.speed_min  <= cfg_data[7:0];
				rcpd_pkg::REG_MOW_MAX:    cfg_q.mow_max    <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// Stage advance: each stage moves when it is empty or its successor moves
	always_comb begin
		adv3       = ~out_valid_q | out_ready;
		adv2       = ~v_s2 | adv3;
		adv1       = ~v_s1 | adv2;
		in_xfer    = in_valid & adv1;
		merge_load = v_s2 & adv3;
		ctl.load_s1 = in_xfer;
		ctl.load_s2 = v_s1 & adv2;
	end

	assign in_ready  = adv1;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv1) begin
				v_s1 <= in_valid;
			end
			if (adv2) begin
				v_s2 <= v_s1;
			end
			if (adv3) begin
				out_valid_q <= v_s2;
			end
		end
	end

	// Timestamp mask and arm window check
	always_comb begin
		time_ext = CMP_W'(time_us);
		t        = time_ext[TIME_WIDTH-1:0];
		win      = CMP_W'(t) < CMP_W'(cfg_q.arm_window);
	end

	always_ff @(posedge clk) begin
		if (ctl.load_s1) begin
			win_s1 <= win;
		end
		if (ctl.load_s2) begin
			win_s2 <= win_s1;
		end
	end

	assign levels[rcpd_pkg::CH_SPEED]  = speed_level;
	assign levels[rcpd_pkg::CH_STEER]  = steer_level;
	assign levels[rcpd_pkg::CH_MOW]    = mow_level;
	assign levels[rcpd_pkg::CH_SWITCH] = switch_level;

	// One decode lane per receiver channel
	for (genvar i = 0; i < rcpd_pkg::NUM_CH; i++) begin : g_lane
		rcpd_lane #(
			.TIME_WIDTH(TIME_WIDTH)
		) u_lane (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.t        (t),
			.level    (levels[i]),
			.center   (cfg_q.center),
			.dead_band(cfg_q.dead_band),
			.res      (lane_res[i])
		);
	end

	// Merge: channel state, arming, mixing, output register
	rcpd_merge u_merge (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (merge_load),
		.lane_res   (lane_res),
		.win        (win_s2),
		.cfg        (cfg_q),
		.speed_pct  (speed_pct),
		.steer_pct  (steer_pct),
		.mow_pct    (mow_pct),
		.switch_pct (switch_pct),
		.left_drive (left_drive),
		.right_drive(right_drive),
		.mow_drive  (mow_drive),
		.armed      (armed)
	);

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

	// One decoded event as seen on the result channel
	typedef struct packed {
		logic signed [rcpd_pkg::PCT_W-1:0]   speed;
		logic signed [rcpd_pkg::PCT_W-1:0]   steer;
		logic [rcpd_pkg::MOW_W-1:0]          mow;
		logic signed [rcpd_pkg::PCT_W-1:0]   sw;
		logic signed [rcpd_pkg::DRIVE_W-1:0] left;
		logic signed [rcpd_pkg::DRIVE_W-1:0] right;
		logic [rcpd_pkg::MOW_W-1:0]          mowd;
		logic                                armed;
	} pulse_res_t;

	// Pin sample: bit c of lv is the level of channel c
	typedef struct packed {
		logic [rcpd_pkg::TS_W-1:0]   t;
		logic [rcpd_pkg::NUM_CH-1:0] lv;
	} pin_sample_t;

	typedef struct packed {
		pin_sample_t smp;
		logic        typed;
		pulse_res_t  res;
	} dir_row_t;

	localparam logic [31:0] T0 = 32'h0100_0000;
	localparam logic [31:0] T1 = 32'h2000_0000;

	// Directed rows; lv is {switch, mow, steer, speed}
	dir_row_t dir_rows [21] = '{
		// after reset, nothing measured yet
		'{'{32'd0, 4'b0000}, 1'b1, '{0, 0, 0, 0, 0, 0, 0, 1'b0}},
		'{'{T0, 4'b1111}, 1'b1, '{0, 0, 0, 0, 0, 0, 0, 1'b0}},
		// full scale both ways, outside the arm window
		'{'{T0 + 32'd2010, 4'b1110}, 1'b1, '{150, 0, 0, 0, 0, 0, 0, 1'b0}},
		'{'{T0 + 32'd990, 4'b1100}, 1'b1, '{150, -150, 0, 0, 0, 0, 0, 1'b0}},
		// mow at center rescales to 50
		'{'{T0 + 32'd1500, 4'b1000}, 1'b1, '{150, -150, 50, 0, 0, 0, 0, 1'b0}},
		// wrapped width saturates high
		'{'{T0 - 32'd1, 4'b0000}, 1'b1, '{150, -150, 50, 150, 0, 0, 0, 1'b0}},
		// rise at max time, fall after wrap
		'{'{32'hFFFF_FFFF, 4'b1111}, 1'b0, '0},
		'{'{32'h0000_0100, 4'b1110}, 1'b0, '0},
		// deadband edges
		'{'{T1, 4'b1111}, 1'b0, '0},
		'{'{T1 + 32'd1517, 4'b1101}, 1'b0, '0},
		'{'{T1 + 32'd1514, 4'b1100}, 1'b0, '0},
		'{'{T1 + 32'd2000, 4'b1111}, 1'b0, '0},
		'{'{T1 + 32'd3483, 4'b1100}, 1'b0, '0},
		'{'{T1 + 32'd3000, 4'b0000}, 1'b0, '0},
		// arming: mow low, speed at threshold, then outside window, then inside
		'{'{32'd1000, 4'b0101}, 1'b0, '0},
		'{'{32'd1990, 4'b0001}, 1'b0, '0},
		'{'{32'd2568, 4'b0000}, 1'b0, '0},
		'{'{32'd9999990, 4'b0001}, 1'b0, '0},
		'{'{32'd10001562, 4'b0000}, 1'b0, '0},
		'{'{32'd9996000, 4'b0001}, 1'b0, '0},
		'{'{32'd9997572, 4'b0000}, 1'b0, '0}
	};

	logic                                clk          = 1'b0;
	logic                                arst_n       = 1'b0;
	logic                                cfg_we       = 1'b0;
	logic [rcpd_pkg::CFG_IDX_W-1:0]      cfg_index    = '0;
	logic [rcpd_pkg::CFG_DATA_W-1:0]     cfg_data     = '0;
	logic                                in_valid     = 1'b0;
	logic                                in_ready;
	logic [rcpd_pkg::TS_W-1:0]           time_us      = '0;
	logic                                speed_level  = 1'b0;
	logic                                steer_level  = 1'b0;
	logic                                mow_level    = 1'b0;
	logic                                switch_level = 1'b0;
	logic                                out_valid;
	logic                                out_ready    = 1'b0;
	logic signed [rcpd_pkg::PCT_W-1:0]   speed_pct;
	logic signed [rcpd_pkg::PCT_W-1:0]   steer_pct;
	logic [rcpd_pkg::MOW_W-1:0]          mow_pct;
	logic signed [rcpd_pkg::PCT_W-1:0]   switch_pct;
	logic signed [rcpd_pkg::DRIVE_W-1:0] left_drive;
	logic signed [rcpd_pkg::DRIVE_W-1:0] right_drive;
	logic [rcpd_pkg::MOW_W-1:0]          mow_drive;
	logic                                armed;

	rc_pulse_decoder_mixer_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.time_us      (time_us),
		.speed_level  (speed_level),
		.steer_level  (steer_level),
		.mow_level    (mow_level),
		.switch_level (switch_level),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.speed_pct    (speed_pct),
		.steer_pct    (steer_pct),
		.mow_pct      (mow_pct),
		.switch_pct   (switch_pct),
		.left_drive   (left_drive),
		.right_drive  (right_drive),
		.mow_drive    (mow_drive),
		.armed        (armed)
	);

	// Decoder copy: registers and per-channel state
	logic [15:0]                 cfg_center = rcpd_pkg::CENTER_RST;
	logic [4:0]                  cfg_db     = rcpd_pkg::DEAD_BAND_RST;
	logic [31:0]                 cfg_window = rcpd_pkg::ARM_WINDOW_RST;
	logic [7:0]                  cfg_smin   = rcpd_pkg::SPEED_MIN_RST;
	logic [7:0]                  cfg_mmax   = rcpd_pkg::MOW_MAX_RST;
	logic [rcpd_pkg::NUM_CH-1:0] last_pins  = '0;
	logic [rcpd_pkg::TS_W-1:0]   rise_at [rcpd_pkg::NUM_CH] = '{default: '0};
	int                          chan_pct [rcpd_pkg::NUM_CH] = '{default: 0};
	logic                        arm_st     = 1'b0;

	pulse_res_t pulse_q [$];
	int         err_cnt = 0;

	// Random pulse train generator state
	logic [rcpd_pkg::TS_W-1:0]   gen_t = '0;
	logic [rcpd_pkg::NUM_CH-1:0] pin_lvl = '0;
	int                          pin_left [rcpd_pkg::NUM_CH] = '{default: 0};
	int                          burst_left = 0;

	// Output side stall state
	int   rdy_span = 0;
	int   stall_left = 0;
	logic rdy_free = 1'b0;

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic int abs_pct(input int v);
		return (v < 0) ? -v : v;
	endfunction

	// Width to percent: 5/17 scaling, saturation, deadband
	function automatic int width_to_pct(input logic [rcpd_pkg::TS_W-1:0] w);
		longint d;
		int     v;
		if (w >= rcpd_pkg::TS_W'(cfg_center)) begin
			d = longint'(w) - longint'(cfg_center);
			v = (d >= 510) ? int'(rcpd_pkg::PCT_LIMIT) : int'(d * 5 / 17);
		end else begin
			d = longint'(cfg_center) - longint'(w);
			v = (d >= 510) ? -int'(rcpd_pkg::PCT_LIMIT) : -int'(d * 5 / 17);
		end
		if (v < int'(cfg_db) && v > -int'(cfg_db))
			v = 0;
		return v;
	endfunction

	// Edge detect, decode, arm test and mixing for one sample
	task automatic predict_event(input pin_sample_t s, output pulse_res_t r);
		int p;
		int spd;
		int str;
		int tw;
		for (int c = 0; c < rcpd_pkg::NUM_CH; c++) begin
			if (s.lv[c] != last_pins[c]) begin
				last_pins[c] = s.lv[c];
				if (s.lv[c]) begin
					rise_at[c] = s.t;
				end else begin
					p = width_to_pct(s.t - rise_at[c]);
					if (c == rcpd_pkg::CH_MOW) begin
						p = (p + 100) / 2;
						if (p < 0)
							p = 0;
					end
					chan_pct[c] = p;
				end
			end
		end
		spd = chan_pct[rcpd_pkg::CH_SPEED];
		str = chan_pct[rcpd_pkg::CH_STEER];
		if (!arm_st && s.t < cfg_window && abs_pct(spd) > int'(cfg_smin) &&
		    abs_pct(chan_pct[rcpd_pkg::CH_MOW]) < int'(cfg_mmax))
			arm_st = 1'b1;
		tw = (spd < 0) ? -str : str;
		r.speed = rcpd_pkg::PCT_W'(spd);
		r.steer = rcpd_pkg::PCT_W'(str);
		r.mow   = rcpd_pkg::MOW_W'(chan_pct[rcpd_pkg::CH_MOW]);
		r.sw    = rcpd_pkg::PCT_W'(chan_pct[rcpd_pkg::CH_SWITCH]);
		r.left  = arm_st ? rcpd_pkg::DRIVE_W'(spd - tw) : '0;
		r.right = arm_st ? rcpd_pkg::DRIVE_W'(spd + tw) : '0;
		r.mowd  = arm_st ? rcpd_pkg::MOW_W'(chan_pct[rcpd_pkg::CH_MOW]) : '0;
		r.armed = arm_st;
	endtask

	// Mostly no gap, sometimes short, rarely long, with gap-free bursts
	function automatic int pick_gap();
		int r;
		if (burst_left > 0) begin
			burst_left--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 10) begin
			burst_left = $urandom_range(20, 60);
			return 0;
		end
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Drive one sample at the falling edge, wait for the transfer, predict
	task automatic send_sample(input pin_sample_t s, output pulse_res_t r);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid     <= 1'b1;
		time_us      <= s.t;
		speed_level  <= s.lv[rcpd_pkg::CH_SPEED];
		steer_level  <= s.lv[rcpd_pkg::CH_STEER];
		mow_level    <= s.lv[rcpd_pkg::CH_MOW];
		switch_level <= s.lv[rcpd_pkg::CH_SWITCH];
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		predict_event(s, r);
		@(negedge clk);
	endtask

	// Hold off until every pending result is out, plus pipeline depth
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pulse_q.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic cfg_write(input logic [rcpd_pkg::CFG_IDX_W-1:0] idx,
	                         input logic [rcpd_pkg::CFG_DATA_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		case (idx)
			rcpd_pkg::REG_CENTER:     cfg_center = data[15:0];
			rcpd_pkg::REG_DEAD_BAND:  cfg_db     = data[4:0];
			rcpd_pkg::REG_ARM_WINDOW: cfg_window = data[31:0];
			rcpd_pkg::REG_SPEED_MIN:  cfg_smin   = data[7:0];
			rcpd_pkg::REG_MOW_MAX:    cfg_mmax   = data[7:0];
			default: ;
		endcase
		@(negedge clk);
	endtask

	// Full register load with junk in the unused upper bits and one stray index
	task automatic load_config(input logic [15:0] ctr, input logic [4:0] db,
	                           input logic [31:0] win, input logic [7:0] smin,
	                           input logic [7:0] mmax);
		logic [31:0] junk;
		junk = $urandom;
		cfg_write(rcpd_pkg::REG_CENTER, {junk[31:16], ctr});
		cfg_write(rcpd_pkg::REG_DEAD_BAND, {junk[31:5], db});
		cfg_write(rcpd_pkg::REG_ARM_WINDOW, win);
		cfg_write(rcpd_pkg::REG_SPEED_MIN, {junk[31:8], smin});
		cfg_write(rcpd_pkg::REG_MOW_MAX, {junk[31:8], mmax});
		cfg_write(rcpd_pkg::CFG_IDX_W'(rcpd_pkg::REG_MOW_MAX + $urandom_range(1, 3)),
		          $urandom);
		cfg_we <= 1'b0;
	endtask

	// Pulse trains around the configured center, with some raw noise samples
	task automatic run_phase(input int n_items, input int pause_at);
		pin_sample_t s;
		pulse_res_t  r;
		int          dt;
		int          step_max;
		step_max = (int'(cfg_center) / 12 > 40) ? int'(cfg_center) / 12 : 40;
		for (int k = 0; k < n_items; k++) begin
			if (k == pause_at)
				wait_idle();
			if ($urandom_range(0, 9) == 0) begin
				s.t  = $urandom;
				s.lv = rcpd_pkg::NUM_CH'($urandom);
			end else begin
				dt = $urandom_range(1, step_max);
				gen_t = gen_t + rcpd_pkg::TS_W'(dt);
				for (int c = 0; c < rcpd_pkg::NUM_CH; c++) begin
					pin_left[c] -= dt;
					if (pin_left[c] <= 0) begin
						pin_lvl[c]  = ~pin_lvl[c];
						pin_left[c] = pin_lvl[c] ?
							int'(cfg_center) + int'($urandom_range(0, 1200)) - 600 :
							int'($urandom_range(200, 3000));
					end
				end
				s.t  = gen_t;
				s.lv = pin_lvl;
			end
			send_sample(s, r);
			pulse_q.push_back(r);
		end
	endtask

	task automatic chk_field(input string nm, input logic signed [31:0] e,
	                         input logic signed [31:0] a);
		if (e !== a) begin
			$display("%0t: %s mismatch: expected %0d, got %0d", $time, nm, e, a);
			err_cnt++;
		end
	endtask

	// Result checker: every transfer against the oldest pending event
	always @(posedge clk) begin
		pulse_res_t e;
		if (out_valid && out_ready) begin
			if (pulse_q.size() == 0) begin
				$display("%0t: result transfer with nothing pending", $time);
				err_cnt++;
			end else begin
				e = pulse_q.pop_front();
				chk_field("speed_pct", 32'(e.speed), 32'(speed_pct));
				chk_field("steer_pct", 32'(e.steer), 32'(steer_pct));
				chk_field("mow_pct", 32'(e.mow), 32'(mow_pct));
				chk_field("switch_pct", 32'(e.sw), 32'(switch_pct));
				chk_field("left_drive", 32'(e.left), 32'(left_drive));
				chk_field("right_drive", 32'(e.right), 32'(right_drive));
				chk_field("mow_drive", 32'(e.mowd), 32'(mow_drive));
				chk_field("armed", 32'(e.armed), 32'(armed));
			end
		end
	end

	// Output backpressure: stretches of free flow and stretches of random stalls
	always @(negedge clk) begin
		if (rdy_span == 0) begin
			rdy_span = $urandom_range(20, 120);
			rdy_free = ($urandom_range(0, 2) == 0);
		end
		rdy_span--;
		if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else if (rdy_free || $urandom_range(0, 99) < 70) begin
			out_ready <= 1'b1;
		end else begin
			stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) :
			             $urandom_range(0, 2);
			out_ready <= 1'b0;
		end
	end

	initial begin
		#5_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	initial begin
		pulse_res_t r;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part at register defaults
		foreach (dir_rows[i]) begin
			send_sample(dir_rows[i].smp, r);
			pulse_q.push_back(dir_rows[i].typed ? dir_rows[i].res : r);
		end
		wait_idle();

		// Random phases over several register settings
		gen_t = $urandom;
		load_config(16'd1500, 5'd0, 32'd0, 8'd0, 8'd0);
		run_phase(80, -1);
		wait_idle();
		gen_t = 32'hFFFF_F000;
		load_config(16'd0, 5'd31, 32'hFFFF_FFFF, 8'd150, 8'd150);
		run_phase(80, 40);
		wait_idle();
		load_config(16'hFFFF, 5'd5, $urandom, 8'($urandom_range(0, 150)),
		            8'($urandom_range(0, 150)));
		run_phase(60, -1);
		wait_idle();
		load_config(16'($urandom_range(0, 3000)), 5'($urandom_range(0, 31)), $urandom,
		            8'($urandom_range(0, 150)), 8'($urandom_range(0, 150)));
		run_phase(90, -1);
		wait_idle();
		load_config(16'($urandom_range(1000, 2000)), 5'($urandom_range(0, 31)), $urandom,
		            8'($urandom_range(0, 150)), 8'($urandom_range(0, 150)));
		run_phase(90, 30);
		wait_idle();

		if (err_cnt == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
